/* sv/rhe_pkg.sv */
// ----------------------------------------------------------------------------
// rhe_pkg: shared types and constants for the record heap engine
// Record layout, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package rhe_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam logic [14:0] KG_PER_LB_Q16 = 15'd29727;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_BMIN   = 3'd2,
        OP_BMAX   = 3'd3,
        OP_YOUNG  = 3'd4,
        OP_INSERT = 3'd5,
        OP_DELOLD = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  age;
        logic [9:0]  height;
        logic [9:0]  weight;
    } t_rec;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] rec_id;
        logic [7:0]  rec_age;
        logic [9:0]  rec_height;
        logic [9:0]  rec_weight;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  entries;
        logic [15:0] res_id;
        logic [7:0]  res_age;
        logic [9:0]  res_weight;
        logic [24:0] kg_q16;
    } t_out_word;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_RD,      // insert: read parent (or place record at root)
        S_UP_CMP,     // insert: compare, maybe swap
        S_BLD_NEXT,   // build: pick next sift root
        S_SD_RDI,     // sift: read node
        S_SD_RDL,     // sift: read left
        S_SD_RDR,     // sift: read right
        S_SD_DEC,     // sift: decide
        S_SD_WR,      // sift: second write of swap
        S_DEL_RD,     // delete: scan read
        S_DEL_CMP,    // delete: scan compare
        S_DEL_LAST,   // delete: read last
        S_DEL_MOVE,   // delete: write last into hole
        S_ROOT_RD,    // read index 0
        S_ROOT_CAP,   // capture root
        S_MUL,        // kg multiply
        S_OUT         // present result
    } t_state;

endpackage

/* sv/rhe_store.sv */
// ----------------------------------------------------------------------------
// rhe_store: record memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rhe_store #(
    parameter int CAPACITY = rhe_pkg::CAPACITY_DEF,
    parameter int AW = $clog2(CAPACITY)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rhe_pkg::t_rec   i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output rhe_pkg::t_rec   o_rdata
);
    rhe_pkg::t_rec r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/record_heap_engine_top.sv */
// ----------------------------------------------------------------------------
// record_heap_engine_top: heap-arranged record store
// Sequencer around one record memory; builds, sifts, inserts and deletes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one command
//   word: operation plus a record for append and insert. Output channel
//   (o_out_valid / i_out_stall / o_out_word) returns one result word per
//   command: status, entry count, root (or deleted) record, and kg in Q.16.
//   One command is worked at a time; o_in_stall is high from acceptance
//   until the result word is taken, and the next word can be taken the
//   cycle after that.
//   Steps from acceptance: clear, append, full store and the unused code
//   read and capture the root, multiply, then present the result;
//   youngest/delete on an empty store go straight to the result; insert
//   reads and compares each parent, and writes the root if it gets there;
//   a build picks each sift root, then per level a record moves down reads
//   node, left and right, decides and writes the swap; youngest weight is
//   a min build plus the multiply; delete-oldest scans every entry, moves
//   the last record into the hole, then rebuilds the min-heap.
//   The result sits in registers; while i_out_stall is high it holds and no
//   new command is taken.
//   Reset (synchronous, active low) empties the store and idles the
//   sequencer; memory contents are not cleared, the count makes them dead.
// ----------------------------------------------------------------------------
module record_heap_engine_top #(
    parameter int CAPACITY = rhe_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rhe_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rhe_pkg::t_out_word   o_out_word
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    rhe_pkg::t_state r_state, n_state;
    rhe_pkg::t_in_word r_cmd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;       // current node / scan index
    logic [CW-1:0] r_bld;     // next build root (counts down)
    logic [CW-1:0] r_best;    // best child index / oldest index
    logic          r_bymax;
    logic          r_isdel;   // build follows a delete
    rhe_pkg::t_rec r_ri, r_rb, r_del;
    rhe_pkg::t_rec r_root;
    logic          r_have_del;
    logic [1:0]    r_status;
    logic [24:0]   r_kg;

    // memory port
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    rhe_pkg::t_rec m_wdata, m_rdata;

    rhe_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    logic [CW:0]   w_l, w_r;
    logic [CW-1:0] w_par;
    assign w_l   = {r_i, 1'b1};
    assign w_r   = {r_i, 1'b0} + (CW+1)'(2);
    assign w_par = (r_i - CW'(1)) >> 1;

    function automatic logic better(input rhe_pkg::t_rec a, input rhe_pkg::t_rec b,
                                    input logic bymax);
        if (bymax) begin
            return a.weight > b.weight;
        end
        return a.age < b.age;
    endfunction

    // sift decision: right child (on m_rdata in S_SD_DEC) against node/left winner
    logic          w_rwin;
    logic [CW-1:0] w_best;
    rhe_pkg::t_rec w_brec;
    assign w_rwin = (w_r < {1'b0, r_count}) && better(m_rdata, r_rb, r_bymax);
    assign w_best = w_rwin ? w_r[CW-1:0] : r_best;
    assign w_brec = w_rwin ? m_rdata : r_rb;

    logic w_accept, w_deliver;
    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_deliver = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != rhe_pkg::S_IDLE);
    assign o_out_valid = (r_state == rhe_pkg::S_OUT);

    rhe_pkg::t_rec w_new;
    assign w_new = '{id: r_cmd.rec_id, age: r_cmd.rec_age,
                     height: r_cmd.rec_height, weight: r_cmd.rec_weight};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rhe_pkg::S_IDLE: begin
                if (w_accept) n_state = rhe_pkg::S_DISPATCH;
            end
            rhe_pkg::S_DISPATCH: begin
                case (rhe_pkg::t_op'(r_cmd.operation))
                    rhe_pkg::OP_APPEND: n_state = rhe_pkg::S_ROOT_RD;
                    rhe_pkg::OP_INSERT:
                        n_state = (r_count >= CAP_C || r_count == '0) ?
                                  rhe_pkg::S_ROOT_RD : rhe_pkg::S_UP_RD;
                    rhe_pkg::OP_BMIN, rhe_pkg::OP_BMAX: n_state = rhe_pkg::S_BLD_NEXT;
                    rhe_pkg::OP_YOUNG:
                        n_state = (r_count == '0) ? rhe_pkg::S_OUT : rhe_pkg::S_BLD_NEXT;
                    rhe_pkg::OP_DELOLD:
                        n_state = (r_count == '0) ? rhe_pkg::S_OUT : rhe_pkg::S_DEL_RD;
                    default: n_state = rhe_pkg::S_ROOT_RD;
                endcase
            end
            rhe_pkg::S_UP_RD:
                n_state = (r_i == '0) ? rhe_pkg::S_ROOT_RD : rhe_pkg::S_UP_CMP;
            rhe_pkg::S_UP_CMP: begin
                if (m_rdata.age > w_new.age) n_state = rhe_pkg::S_UP_RD;
                else n_state = rhe_pkg::S_ROOT_RD;
            end
            rhe_pkg::S_BLD_NEXT:
                n_state = (r_bld == '0) ? rhe_pkg::S_ROOT_RD : rhe_pkg::S_SD_RDI;
            rhe_pkg::S_SD_RDI: n_state = rhe_pkg::S_SD_RDL;
            rhe_pkg::S_SD_RDL: begin
                if (w_l < {1'b0, r_count}) n_state = rhe_pkg::S_SD_RDR;
                else n_state = rhe_pkg::S_BLD_NEXT;
            end
            rhe_pkg::S_SD_RDR: n_state = rhe_pkg::S_SD_DEC;
            rhe_pkg::S_SD_DEC: begin
                if (w_best == r_i) n_state = rhe_pkg::S_BLD_NEXT;
                else n_state = rhe_pkg::S_SD_WR;
            end
            rhe_pkg::S_SD_WR:  n_state = rhe_pkg::S_SD_RDI;
            rhe_pkg::S_DEL_RD: n_state = rhe_pkg::S_DEL_CMP;
            rhe_pkg::S_DEL_CMP:
                n_state = (r_i + CW'(1) >= r_count) ? rhe_pkg::S_DEL_LAST : rhe_pkg::S_DEL_RD;
            rhe_pkg::S_DEL_LAST: n_state = rhe_pkg::S_DEL_MOVE;
            rhe_pkg::S_DEL_MOVE: n_state = rhe_pkg::S_BLD_NEXT;
            rhe_pkg::S_ROOT_RD:  n_state = rhe_pkg::S_ROOT_CAP;
            rhe_pkg::S_ROOT_CAP: n_state = rhe_pkg::S_MUL;
            rhe_pkg::S_MUL:      n_state = rhe_pkg::S_OUT;
            rhe_pkg::S_OUT: begin
                if (w_deliver) n_state = rhe_pkg::S_IDLE;
            end
            default: n_state = rhe_pkg::S_IDLE;
        endcase
    end

    // memory port drive
    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_i[AW-1:0];
        m_wdata = r_ri;
        m_raddr = r_i[AW-1:0];
        case (r_state)
            rhe_pkg::S_DISPATCH: begin
                if ((r_cmd.operation == rhe_pkg::OP_APPEND ||
                     r_cmd.operation == rhe_pkg::OP_INSERT) && r_count < CAP_C) begin
                    m_we    = 1'b1;
                    m_waddr = r_count[AW-1:0];
                    m_wdata = w_new;
                end
            end
            rhe_pkg::S_UP_RD: begin
                m_raddr = w_par[AW-1:0];
                if (r_i == '0) begin
                    // new record climbed to the root
                    m_we    = 1'b1;
                    m_waddr = '0;
                    m_wdata = w_new;
                end
            end
            rhe_pkg::S_UP_CMP: begin
                if (m_rdata.age > w_new.age) begin
                    // parent moves down, new record moves up
                    m_we    = 1'b1;
                    m_waddr = r_i[AW-1:0];
                    m_wdata = m_rdata;
                end else begin
                    m_we    = 1'b1;
                    m_waddr = r_i[AW-1:0];
                    m_wdata = w_new;
                end
            end
            rhe_pkg::S_SD_RDI: m_raddr = r_i[AW-1:0];
            rhe_pkg::S_SD_RDL: m_raddr = w_l[AW-1:0];
            rhe_pkg::S_SD_RDR: m_raddr = w_r[AW-1:0];
            rhe_pkg::S_SD_DEC: begin
                if (w_best != r_i) begin
                    m_we    = 1'b1;
                    m_waddr = r_i[AW-1:0];
                    m_wdata = w_brec;
                end
            end
            rhe_pkg::S_SD_WR: begin
                m_we    = 1'b1;
                m_waddr = r_best[AW-1:0];
                m_wdata = r_ri;
            end
            rhe_pkg::S_DEL_RD:   m_raddr = r_i[AW-1:0];
            rhe_pkg::S_DEL_LAST: m_raddr = AW'(r_count - CW'(1));
            rhe_pkg::S_DEL_MOVE: begin
                m_we    = 1'b1;
                m_waddr = r_best[AW-1:0];
                m_wdata = m_rdata;
            end
            rhe_pkg::S_ROOT_RD: m_raddr = '0;
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rhe_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rhe_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= i_in_word;
                        r_status   <= rhe_pkg::ST_OK;
                        r_have_del <= 1'b0;
                        r_kg       <= '0;
                        r_isdel    <= 1'b0;
                    end
                end
                rhe_pkg::S_DISPATCH: begin
                    r_bymax <= (r_cmd.operation == rhe_pkg::OP_BMAX);
                    r_bld   <= r_count >> 1;
                    r_i     <= (r_cmd.operation == rhe_pkg::OP_DELOLD) ? '0 : r_count;
                    case (rhe_pkg::t_op'(r_cmd.operation))
                        rhe_pkg::OP_CLEAR: r_count <= '0;
                        rhe_pkg::OP_APPEND, rhe_pkg::OP_INSERT: begin
                            if (r_count >= CAP_C) r_status <= rhe_pkg::ST_FULL;
                            else r_count <= r_count + CW'(1);
                        end
                        rhe_pkg::OP_YOUNG: begin
                            if (r_count == '0) r_status <= rhe_pkg::ST_EMPTY;
                        end
                        rhe_pkg::OP_DELOLD: begin
                            if (r_count == '0) r_status <= rhe_pkg::ST_EMPTY;
                            r_best  <= '0;
                            r_isdel <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                rhe_pkg::S_UP_CMP: begin
                    if (m_rdata.age > w_new.age) r_i <= w_par;
                end
                rhe_pkg::S_BLD_NEXT: begin
                    if (r_bld != '0) begin
                        r_i   <= r_bld - CW'(1);
                        r_bld <= r_bld - CW'(1);
                    end
                end
                rhe_pkg::S_SD_RDL: begin
                    r_ri   <= m_rdata;
                    r_rb   <= m_rdata;
                    r_best <= r_i;
                end
                rhe_pkg::S_SD_RDR: begin
                    if (better(m_rdata, r_ri, r_bymax)) begin
                        r_rb   <= m_rdata;
                        r_best <= w_l[CW-1:0];
                    end
                end
                rhe_pkg::S_SD_DEC: begin
                    r_rb   <= w_brec;
                    r_best <= w_best;
                end
                rhe_pkg::S_SD_WR: r_i <= r_best;
                rhe_pkg::S_DEL_CMP: begin
                    if (r_i == '0 || m_rdata.age > r_del.age) begin
                        r_del  <= m_rdata;
                        r_best <= r_i;
                    end
                    r_i <= r_i + CW'(1);
                end
                rhe_pkg::S_DEL_LAST: begin
                    r_count    <= r_count - CW'(1);
                    r_have_del <= 1'b1;
                end
                rhe_pkg::S_DEL_MOVE: begin
                    r_bld <= r_count >> 1;
                end
                rhe_pkg::S_ROOT_CAP: r_root <= m_rdata;
                rhe_pkg::S_MUL: begin
                    if (r_cmd.operation == rhe_pkg::OP_YOUNG && !r_isdel)
                        r_kg <= 25'(r_root.weight) * 25'(rhe_pkg::KG_PER_LB_Q16);
                end
                default: ;
            endcase
        end
    end

    // output word
    always_comb begin
        o_out_word = '0;
        o_out_word.status  = r_status;
        o_out_word.entries = 7'(r_count);
        o_out_word.kg_q16  = r_kg;
        if (r_have_del) begin
            o_out_word.res_id     = r_del.id;
            o_out_word.res_age    = r_del.age;
            o_out_word.res_weight = r_del.weight;
        end else if (r_count != '0) begin
            o_out_word.res_id     = r_root.id;
            o_out_word.res_age    = r_root.age;
            o_out_word.res_weight = r_root.weight;
        end
    end
endmodule

/* sv/rhe_checker.sv */
// ----------------------------------------------------------------------------
// rhe_checker: port-level checks for the record heap engine
// Watches handshakes and result fields at the top level ports.
// ----------------------------------------------------------------------------
module rhe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rhe_pkg::t_out_word o_out_word
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result changed while stalled");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("command taken with result pending");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off after a command word");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.status <= rhe_pkg::ST_FULL)
        else $error("bad status");

    a_kg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != rhe_pkg::ST_OK |-> o_out_word.kg_q16 == '0)
        else $error("kg set on failed command");
endmodule

bind record_heap_engine_top rhe_checker u_rhe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

/* verif/tb_record_heap_engine_top.sv */
// ----------------------------------------------------------------------------
// tb_record_heap_engine_top: self-checking bench for the record heap engine
// Directed table then random command words; every result word is checked
// against an in-bench heap predictor, under several idle/stall phases.
// ----------------------------------------------------------------------------
module tb_record_heap_engine_top;

    localparam int CAP         = rhe_pkg::CAPACITY_DEF;
    localparam int N_RANDOM    = 1080;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    rhe_pkg::t_in_word   i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    rhe_pkg::t_out_word  o_out_word;

    record_heap_engine_top #(.CAPACITY(CAP)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor: mirror of the record store ----------------
    rhe_pkg::t_rec       heap_mem [CAP];
    int                  heap_cnt;

    rhe_pkg::t_out_word  pending_q[$];
    rhe_pkg::t_out_word  last_out;
    int                  n_errors;
    int                  n_checked;
    int                  op_seen[8];
    int                  n_full;
    int                  n_empty;

    // age-min or weight-max comparison on two slots
    function automatic bit key_wins(int a, int b, bit by_wt);
        if (by_wt) return heap_mem[a].weight > heap_mem[b].weight;
        return heap_mem[a].age < heap_mem[b].age;
    endfunction

    task automatic sift_node(int i, bit by_wt);
        int            best;
        int            l;
        int            r;
        rhe_pkg::t_rec tmp;
        forever begin
            best = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < heap_cnt && key_wins(l, best, by_wt)) best = l;
            if (r < heap_cnt && key_wins(r, best, by_wt)) best = r;
            if (best == i) return;
            tmp = heap_mem[i];
            heap_mem[i] = heap_mem[best];
            heap_mem[best] = tmp;
            i = best;
        end
    endtask

    task automatic heapify(bit by_wt);
        for (int i = heap_cnt / 2 - 1; i >= 0; i--) sift_node(i, by_wt);
    endtask

    // apply one command word to the mirror, return the expected result word
    task automatic heap_apply(input rhe_pkg::t_in_word w, output rhe_pkg::t_out_word res);
        rhe_pkg::t_rec nr;
        rhe_pkg::t_rec rep;
        bit            have_rep;
        int            idx;
        int            old;
        rhe_pkg::t_rec tmp;
        nr       = '{id: w.rec_id, age: w.rec_age, height: w.rec_height,
                     weight: w.rec_weight};
        rep      = '0;
        have_rep = 0;
        res      = '0;
        res.status = rhe_pkg::ST_OK;
        case (rhe_pkg::t_op'(w.operation))
            rhe_pkg::OP_CLEAR: heap_cnt = 0;
            rhe_pkg::OP_APPEND: begin
                if (heap_cnt >= CAP) res.status = rhe_pkg::ST_FULL;
                else begin
                    heap_mem[heap_cnt] = nr;
                    heap_cnt++;
                end
            end
            rhe_pkg::OP_BMIN: heapify(0);
            rhe_pkg::OP_BMAX: heapify(1);
            rhe_pkg::OP_YOUNG: begin
                if (heap_cnt == 0) res.status = rhe_pkg::ST_EMPTY;
                else begin
                    heapify(0);
                    res.kg_q16 = 25'(int'(heap_mem[0].weight) *
                                     int'(rhe_pkg::KG_PER_LB_Q16));
                end
            end
            rhe_pkg::OP_INSERT: begin
                if (heap_cnt >= CAP) res.status = rhe_pkg::ST_FULL;
                else begin
                    idx = heap_cnt;
                    heap_mem[idx] = nr;
                    heap_cnt++;
                    while (idx != 0 && heap_mem[(idx - 1) / 2].age > heap_mem[idx].age) begin
                        tmp = heap_mem[idx];
                        heap_mem[idx] = heap_mem[(idx - 1) / 2];
                        heap_mem[(idx - 1) / 2] = tmp;
                        idx = (idx - 1) / 2;
                    end
                end
            end
            rhe_pkg::OP_DELOLD: begin
                if (heap_cnt == 0) res.status = rhe_pkg::ST_EMPTY;
                else begin
                    old = 0;
                    for (int i = 1; i < heap_cnt; i++)
                        if (heap_mem[i].age > heap_mem[old].age) old = i;
                    rep = heap_mem[old];
                    have_rep = 1;
                    heap_mem[old] = heap_mem[heap_cnt - 1];
                    heap_cnt--;
                    if (heap_cnt > 0) heapify(0);
                end
            end
            default: ;
        endcase
        if (!have_rep && heap_cnt > 0) rep = heap_mem[0];
        res.entries    = 7'(heap_cnt);
        res.res_id     = rep.id;
        res.res_age    = rep.age;
        res.res_weight = rep.weight;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // ---------------- stimulus control ----------------
    int idle_pct;      // sender gap chance
    int stall_pct;     // receiver stall chance
    bit hold_off;      // long receiver hold-off
    int cycle_cnt;

    // directed table; typed expectation only where obvious
    typedef struct {
        rhe_pkg::t_in_word  w;
        bit                 typed;
        rhe_pkg::t_out_word res;
    } t_row;
    t_row dir_tab[$];

    function automatic rhe_pkg::t_in_word mk(rhe_pkg::t_op op, int id, int age, int ht,
                                             int wt);
        rhe_pkg::t_in_word w;
        w.operation  = op;
        w.rec_id     = 16'(id);
        w.rec_age    = 8'(age);
        w.rec_height = 10'(ht);
        w.rec_weight = 10'(wt);
        return w;
    endfunction

    function automatic rhe_pkg::t_out_word mk_res(rhe_pkg::t_status st, int n, int id,
                                                  int age, int wt, int kg);
        rhe_pkg::t_out_word r;
        r.status = st; r.entries = 7'(n); r.res_id = 16'(id);
        r.res_age = 8'(age); r.res_weight = 10'(wt); r.kg_q16 = 25'(kg);
        return r;
    endfunction

    // random record content with corner bias
    function automatic rhe_pkg::t_in_word rand_word(rhe_pkg::t_op op);
        rhe_pkg::t_in_word w;
        w = mk(op, $urandom_range(0, 65535), $urandom_range(0, 255),
               $urandom_range(0, 1023), $urandom_range(0, 1023));
        if ($urandom_range(0, 9) == 0) w.rec_age = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 9) == 0) w.rec_weight = $urandom_range(0, 1) ? 10'h3FF : 10'h0;
        if ($urandom_range(0, 15) == 0) w.rec_age = 8'(heap_cnt); // ties
        return w;
    endfunction

    // send one word: step off the last drop, gap, then hold valid until accepted
    task automatic send_word(rhe_pkg::t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(1, 100) <= idle_pct) @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // models expectation at accept time, in order
    always @(posedge i_clk) begin
        rhe_pkg::t_out_word r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            heap_apply(i_in_word, r);
            op_seen[i_in_word.operation]++;
            if (r.status == rhe_pkg::ST_FULL) n_full++;
            if (r.status == rhe_pkg::ST_EMPTY) n_empty++;
            pending_q.push_back(r);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        rhe_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            last_out = o_out_word;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result word, entries", o_out_word.entries, -1);
            end else begin
                want = pending_q.pop_front();
                n_checked++;
                if (o_out_word.status !== want.status)
                    report_mismatch("status", o_out_word.status, want.status);
                if (o_out_word.entries !== want.entries)
                    report_mismatch("entries", o_out_word.entries, want.entries);
                if (o_out_word.res_id !== want.res_id)
                    report_mismatch("res_id", o_out_word.res_id, want.res_id);
                if (o_out_word.res_age !== want.res_age)
                    report_mismatch("res_age", o_out_word.res_age, want.res_age);
                if (o_out_word.res_weight !== want.res_weight)
                    report_mismatch("res_weight", o_out_word.res_weight, want.res_weight);
                if (o_out_word.kg_q16 !== want.kg_q16)
                    report_mismatch("kg_q16", o_out_word.kg_q16, want.kg_q16);
            end
        end
    end

    // receiver stall driver
    always @(negedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // long receiver hold-off counted in its own process
    task automatic long_hold(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(negedge i_clk);
        hold_off = 1'b0;
    endtask

    // random phase: mostly filled-store traffic, occasional clear
    task automatic random_phase(int n);
        rhe_pkg::t_op op;
        int           pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) op = rhe_pkg::OP_CLEAR;
            else if (pick < 30) op = rhe_pkg::OP_APPEND;
            else if (pick < 55) op = rhe_pkg::OP_INSERT;
            else if (pick < 62) op = rhe_pkg::OP_BMIN;
            else if (pick < 69) op = rhe_pkg::OP_BMAX;
            else if (pick < 79) op = rhe_pkg::OP_YOUNG;
            else if (pick < 97) op = rhe_pkg::OP_DELOLD;
            else op = rhe_pkg::OP_NONE;
            send_word(rand_word(op));
        end
    endtask

    initial begin
        t_row row;
        n_errors = 0; n_checked = 0; n_full = 0; n_empty = 0;
        cycle_cnt = 0; heap_cnt = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        idle_pct = 0; stall_pct = 0; hold_off = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_word = '0; i_out_stall = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty cases, extremes, every operation
        dir_tab.push_back('{mk(rhe_pkg::OP_YOUNG, 0, 0, 0, 0), 1,
                            mk_res(rhe_pkg::ST_EMPTY, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(rhe_pkg::OP_DELOLD, 0, 0, 0, 0), 1,
                            mk_res(rhe_pkg::ST_EMPTY, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(rhe_pkg::OP_BMIN, 0, 0, 0, 0), 1,
                            mk_res(rhe_pkg::ST_OK, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(rhe_pkg::OP_BMAX, 0, 0, 0, 0), 1,
                            mk_res(rhe_pkg::ST_OK, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(rhe_pkg::OP_NONE, 0, 0, 0, 0), 1,
                            mk_res(rhe_pkg::ST_OK, 0, 0, 0, 0, 0)});
        dir_tab.push_back('{mk(rhe_pkg::OP_APPEND, 65535, 255, 1023, 1023), 1,
                            mk_res(rhe_pkg::ST_OK, 1, 65535, 255, 1023, 0)});
        dir_tab.push_back('{mk(rhe_pkg::OP_YOUNG, 0, 0, 0, 0), 1,
                            mk_res(rhe_pkg::ST_OK, 1, 65535, 255, 1023, 1023 * 29727)});
        dir_tab.push_back('{mk(rhe_pkg::OP_APPEND, 1, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_APPEND, 2, 40, 500, 700), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_APPEND, 3, 40, 12, 700), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_BMAX, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_BMIN, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_INSERT, 4, 20, 1, 2), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_DELOLD, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_YOUNG, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_NONE, 0, 0, 0, 0), 0, '0});
        dir_tab.push_back('{mk(rhe_pkg::OP_CLEAR, 0, 0, 0, 0), 1,
                            mk_res(rhe_pkg::ST_OK, 0, 0, 0, 0, 0)});
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            send_word(row.w);
            wait (pending_q.size() == 0);
            if (row.typed && last_out !== row.res)
                report_mismatch("directed row entries", last_out.entries, row.res.entries);
            @(negedge i_clk);
        end

        // fill past capacity so full status is reached, with the long hold-off
        fork
            long_hold(3000);
            for (int k = 0; k < CAP + 3; k++)
                send_word(rand_word($urandom_range(0, 1) ? rhe_pkg::OP_APPEND :
                                                           rhe_pkg::OP_INSERT));
        join
        send_word(rand_word(rhe_pkg::OP_DELOLD));

        // random phases under varied pressure
        idle_pct = 0;  stall_pct = 0;  random_phase(N_RANDOM / 4);
        idle_pct = 80; stall_pct = 0;  random_phase(N_RANDOM / 4);
        idle_pct = 0;  stall_pct = 80; random_phase(N_RANDOM / 4);
        idle_pct = 30; stall_pct = 30; random_phase(N_RANDOM / 4);

        wait (pending_q.size() == 0);
        repeat (DRAIN_WAIT / 100) @(negedge i_clk);
        $display("checked %0d result words; %0d full and %0d empty replies",
                 n_checked, n_full, n_empty);
        $display("ops seen: clr %0d app %0d min %0d max %0d yng %0d ins %0d del %0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
                 op_seen[6]);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* record_heap_engine_top.f */
sv/rhe_pkg.sv
sv/rhe_store.sv
sv/record_heap_engine_top.sv
sv/rhe_checker.sv
verif/tb_record_heap_engine_top.sv
